[rtl/stil_pkg.sv]
// Package for the sorted-table interval locator.
// Holds sizes, operation and register codes, and the controller/datapath types.
// No dependencies.
package stil_pkg;

    localparam int DEPTH  = 1024;
    localparam int KEY_W  = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = 11;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic CFG_ENTRY_COUNT = 1'b0;
    localparam logic CFG_ZERO_BASED  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK_FIRST,
        ST_CHK_LAST,
        ST_PROBE,
        ST_FINAL,
        ST_RESULT
    } state_t;

    typedef enum logic [1:0] {
        RD_ZERO,
        RD_LAST,
        RD_MID,
        RD_LO
    } rd_sel_t;

    typedef enum logic [1:0] {
        POS_ONE,
        POS_COUNT,
        POS_FINAL
    } pos_sel_t;

    typedef struct packed {
        logic     wr_en;
        logic     capture;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     init_bounds;
        logic     step_bounds;
        logic     set_pos;
        pos_sel_t pos_sel;
        logic     load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic key_le;
        logic key_ge;
        logic span_gt1;
    } dp_status_t;

endpackage

[rtl/stil_datapath.sv]
// Datapath of the interval locator: key table memory, config registers,
// search bounds and the result register. Depends on stil_pkg.
module stil_datapath import stil_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  dp_cmd_t                  cmd,
    output dp_status_t               status,
    input  logic                     cfg_valid,
    input  logic                     cfg_index,
    input  logic [CNT_W-1:0]         cfg_data,
    input  logic [ADDR_W-1:0]        s_entry_index,
    input  logic signed [KEY_W-1:0]  s_entry_value,
    input  logic signed [KEY_W-1:0]  s_query_key,
    output logic [CNT_W-1:0]         m_position
);

    logic signed [KEY_W-1:0] mem [DEPTH];
    logic signed [KEY_W-1:0] rdata_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [CNT_W-1:0]        entry_count_reg;
    logic                    zero_based_reg;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic [CNT_W-1:0]        lo_reg, lo_next;
    logic [CNT_W-1:0]        hi_reg, hi_next;
    logic [CNT_W-1:0]        mid_reg, mid_next;
    logic [CNT_W-1:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]        m_position_reg;
    logic [CNT_W:0]          sum;
    logic [CNT_W-1:0]        span;
    logic [CNT_W-1:0]        rd_addr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= CNT_W'(1);
            zero_based_reg  <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ENTRY_COUNT: entry_count_reg <= cfg_data;
                CFG_ZERO_BASED:  zero_based_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamp the count to 1..DEPTH
    always_comb begin
        if (entry_count_reg == '0) begin
            n_next = CNT_W'(1);
        end else if (entry_count_reg > CNT_W'(DEPTH)) begin
            n_next = CNT_W'(DEPTH);
        end else begin
            n_next = entry_count_reg;
        end
    end

    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (cmd.init_bounds) begin
            lo_next = '0;
            hi_next = n_reg + CNT_W'(1);
        end else if (cmd.step_bounds) begin
            if (key_reg > rdata_reg) begin
                lo_next = mid_reg;
            end else begin
                hi_next = mid_reg;
            end
        end
        sum      = {1'b0, lo_next} + {1'b0, hi_next};
        mid_next = sum[CNT_W:1];
        span     = hi_next - lo_next;
    end

    always_comb begin
        unique case (cmd.rd_sel)
            RD_ZERO: rd_addr = '0;
            RD_LAST: rd_addr = n_reg - CNT_W'(1);
            RD_MID:  rd_addr = mid_next - CNT_W'(1);
            RD_LO:   rd_addr = lo_next;
            default: rd_addr = '0;
        endcase
    end

    always_comb begin
        unique case (cmd.pos_sel)
            POS_ONE:   pos_next = CNT_W'(1);
            POS_COUNT: pos_next = n_reg;
            POS_FINAL: pos_next = lo_reg + CNT_W'(rdata_reg == key_reg);
            default:   pos_next = CNT_W'(1);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[s_entry_index] <= s_entry_value;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_addr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            key_reg <= s_query_key;
            n_reg   <= n_next;
        end
        if (cmd.init_bounds || cmd.step_bounds) begin
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            mid_reg <= mid_next;
        end
        if (cmd.set_pos) begin
            pos_reg <= pos_next;
        end
        if (cmd.load_out) begin
            m_position_reg <= pos_reg - CNT_W'(zero_based_reg);
        end
    end

    assign status.key_le   = key_reg <= rdata_reg;
    assign status.key_ge   = key_reg >= rdata_reg;
    assign status.span_gt1 = span > CNT_W'(1);
    assign m_position      = m_position_reg;

endmodule

[rtl/stil_ctrl.sv]
// Controller of the interval locator: sequences boundary checks, bisection
// probes and the final equality check. Depends on stil_pkg.
module stil_ctrl import stil_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_operation,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_operation == OP_QUERY) state_next = ST_CHK_FIRST;
            end
            ST_CHK_FIRST: begin
                state_next = status.key_le ? ST_RESULT : ST_CHK_LAST;
            end
            ST_CHK_LAST: begin
                state_next = status.key_ge ? ST_RESULT : ST_PROBE;
            end
            ST_PROBE: begin
                if (!status.span_gt1) state_next = ST_FINAL;
            end
            ST_FINAL: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.rd_sel  = RD_ZERO;
        cmd.pos_sel = POS_ONE;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.wr_en   = accept && s_operation == OP_LOAD;
                cmd.capture = accept && s_operation == OP_QUERY;
                cmd.rd_en   = accept && s_operation == OP_QUERY;
            end
            ST_CHK_FIRST: begin
                if (status.key_le) begin
                    cmd.set_pos = 1'b1;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_LAST;
                end
            end
            ST_CHK_LAST: begin
                if (status.key_ge) begin
                    cmd.set_pos = 1'b1;
                    cmd.pos_sel = POS_COUNT;
                end else begin
                    cmd.init_bounds = 1'b1;
                    cmd.rd_en       = 1'b1;
                    cmd.rd_sel      = RD_MID;
                end
            end
            ST_PROBE: begin
                cmd.step_bounds = 1'b1;
                cmd.rd_en       = 1'b1;
                cmd.rd_sel      = status.span_gt1 ? RD_MID : RD_LO;
            end
            ST_FINAL: begin
                cmd.set_pos = 1'b1;
                cmd.pos_sel = POS_FINAL;
            end
            ST_RESULT: begin
                cmd.load_out = out_free;
            end
            default: ;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

[rtl/sorted_table_interval_locate.sv]
// Sequencing: a load transaction gives no result. A query for a key at or below the first
// entry goes from the first-entry check to the result; one at or above the last goes on
// through the last-entry check; otherwise bisection probes follow, one read per probe.
// Throughput: one load per cycle while no query is in progress; a query holds the input,
// also through an output stall, until its result is loaded, and s_ready returns with m_valid.
// Reset (aresetn low, synchronous): controller idle, no result pending, entry_count = 1,
// zero_based = 0; table contents stay undefined until loaded.
module sorted_table_interval_locate import stil_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic                     cfg_index,
    input  logic [CNT_W-1:0]         cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_operation,
    input  logic [ADDR_W-1:0]        s_entry_index,
    input  logic signed [KEY_W-1:0]  s_entry_value,
    input  logic signed [KEY_W-1:0]  s_query_key,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [CNT_W-1:0]         m_position
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    stil_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .status      (status),
        .cmd         (cmd)
    );

    stil_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_entry_index (s_entry_index),
        .s_entry_value (s_entry_value),
        .s_query_key   (s_query_key),
        .m_position    (m_position)
    );

endmodule

[rtl/stil_checker.sv]
// Port-level checker for the interval locator, bound to the top level.
// Depends on stil_pkg.
module stil_checker import stil_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             s_operation,
    input logic             m_valid,
    input logic             m_ready,
    input logic [CNT_W-1:0] m_position
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_position))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("not idle after reset");

    // a query transaction occupies the search engine on the next cycle
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_operation == OP_QUERY |=> !s_ready)
        else $error("input taken during a search");

    // a load on an empty output never yields a result
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_operation == OP_LOAD && !m_valid |=> !m_valid)
        else $error("load produced a result");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_position <= CNT_W'(DEPTH))
        else $error("position out of range");

endmodule

bind sorted_table_interval_locate stil_checker u_stil_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_operation (s_operation),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_position  (m_position)
);
